### design/bcow_pkg.sv
// shared types and constants for the bucketed call outcome window
package bcow_pkg;

   localparam int MAX_BUCKETS_DEF = 64;
   localparam int NUM_CLASSES_DEF = 4;
   localparam int CNT_W = 32;
   localparam int TIME_W = 48;
   localparam int DUR_W = 32;
   localparam int BCNT_W = 7;
   localparam int ENTRY_W = 35;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 35;
   localparam int NUM_ENTRIES = 4;

   localparam logic [CSR_IDX_W-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DUR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BCNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY0 = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ERR = 2'd1;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // divider request and answer
   typedef struct packed {
      logic start;
      logic [TIME_W-1:0] dividend;
      logic [DUR_W-1:0] divisor;
      logic [BCNT_W-1:0] modulus;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [BCNT_W-1:0] bucket;
   } div_rsp_type;

endpackage

### design/bcow_div.sv
// serial restoring divider giving (time / duration) mod bucket count
module bcow_div (
   input  logic clock,
   input  logic reset,
   input  bcow_pkg::div_req_type req,
   output bcow_pkg::div_rsp_type rsp
);
   localparam int TW = bcow_pkg::TIME_W;
   localparam int DW = bcow_pkg::DUR_W;
   localparam int BW = bcow_pkg::BCNT_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_MOD  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [BW-1:0] mod_ff, mod_in;
   logic [5:0] cnt_ff, cnt_in;
   // remainder of quotient by modulus, folded one quotient bit a step
   logic [BW:0] mrem_ff, mrem_in;
   logic done_ff, done_in;

   logic [DW:0] trial;
   logic [BW+1:0] mtrial;

   always_comb begin
      state_in = state_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      mod_in = mod_ff;
      cnt_in = cnt_ff;
      mrem_in = mrem_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[TW-1]};
      mtrial = {mrem_ff, quo_ff[TW-1]};
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               quo_in = req.dividend;
               rem_in = '0;
               dsr_in = (req.divisor == '0) ? DW'(1) : req.divisor;
               mod_in = req.modulus;
               cnt_in = 6'(TW);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in = DW'(trial - {1'b0, dsr_ff});
               quo_in = {quo_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = trial[DW-1:0];
               quo_in = {quo_ff[TW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               cnt_in = 6'(TW);
               mrem_in = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            // remainder stays below modulus, one compare and subtract per bit
            if (mtrial >= {2'b00, mod_ff}) begin
               mrem_in = (BW+1)'(mtrial - {2'b00, mod_ff});
            end else begin
               mrem_in = mtrial[BW:0];
            end
            quo_in = {quo_ff[TW-2:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               done_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      mod_ff <= mod_in;
      cnt_ff <= cnt_in;
      mrem_ff <= mrem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.bucket = mrem_ff[BW-1:0];

   // a result only follows the modulo phase
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == S_MOD)
      else $error("divider done outside modulo phase");
   // remainder of the modulo phase stays below the modulus
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, mrem_ff[BW-1:0]} < {1'b0, mod_ff}))
      else $error("bucket index not below count");
   // start is only honored from idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req.start) |=> state_ff == S_DIV)
      else $error("divider did not start");
endmodule

### design/bucketed_call_outcome_window.sv
// top level of the bucketed call outcome window: sequencer, counters and config
//
// Input channel req_ takes one transaction: a record of one call outcome or a
// drain request (req_tuser is the kind). Each transaction first runs a serial
// divide of the time by the bucket duration and then a modulo by the bucket
// count, one bit per cycle, to find the bucket index. A record then spends a
// read state and a write state on the counter memory and returns nothing;
// req_tready is low until it is done.
// A drain then walks from the current bucket downward with wrap, reading and
// then clearing each bucket and putting one transaction on rsp_ per bucket;
// rsp_tlast marks the last. A drain holds req_tready low until its last bucket
// is presented. A result sits in an output register, so the walk waits while
// rsp_tready is low and nothing is lost.
// Reset clears the registers to their defaults and then runs a clearing pass
// over all MAX_BUCKETS rows of the counter memory, one bucket per cycle, while
// req_tready stays low. Config writes on csr_ belong between transactions.
module bucketed_call_outcome_window #(
   parameter int MAX_BUCKETS = bcow_pkg::MAX_BUCKETS_DEF,
   parameter int NUM_CLASSES = bcow_pkg::NUM_CLASSES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // time_ms [47:0], call_status [49:48], delay_ms [81:50], return code [113:82]
   input  logic [119:0] req_tdata,
   // kind [0]
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // bucket_age [5:0], total, error, slow, class0..class3 counts 32 bits each
   output logic [231:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [bcow_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcow_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int CW = bcow_pkg::CNT_W;
   localparam int BW = bcow_pkg::BCNT_W;
   localparam int AW = $clog2(MAX_BUCKETS);
   localparam int LIM = (MAX_BUCKETS < 64) ? MAX_BUCKETS : 64;
   localparam int ROW_W = CW * (3 + NUM_CLASSES);
   localparam logic [CW-1:0] CNT_MAX = '1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_RREAD = 7'b0001000,
      S_RWRT  = 7'b0010000,
      S_DREAD = 7'b0100000,
      S_DOUT  = 7'b1000000
   } state_type;

   // config registers
   logic [1:0] mode_ff;
   logic [CW-1:0] slow_ff;
   logic [bcow_pkg::DUR_W-1:0] dur_ff;
   logic [BW-1:0] bcnt_ff;
   logic [bcow_pkg::ENTRY_W-1:0] entry_ff [bcow_pkg::NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         slow_ff <= '0;
         dur_ff <= 32'd1000;
         bcnt_ff <= 7'd23;
         for (int i = 0; i < bcow_pkg::NUM_ENTRIES; i++) entry_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bcow_pkg::REG_MODE: mode_ff <= csr_wdata[1:0];
            bcow_pkg::REG_SLOW: slow_ff <= csr_wdata[CW-1:0];
            bcow_pkg::REG_DUR: dur_ff <= csr_wdata[CW-1:0];
            bcow_pkg::REG_BCNT: bcnt_ff <= csr_wdata[BW-1:0];
            default: begin
               if (csr_index >= bcow_pkg::REG_ENTRY0)
                  entry_ff[2'(csr_index - bcow_pkg::REG_ENTRY0)] <= csr_wdata;
            end
         endcase
      end
   end

   // effective bucket count
   logic [BW-1:0] ncnt;
   always_comb begin
      ncnt = bcnt_ff;
      if (bcnt_ff == '0) ncnt = BW'(1);
      if (bcnt_ff > BW'(LIM)) ncnt = BW'(LIM);
   end

   // sequencer state and item registers
   state_type state_ff, state_in;
   logic kind_ff;
   logic [1:0] stat_ff;
   logic [CW-1:0] delay_ff;
   logic [CW-1:0] code_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [BW-1:0] age_ff, age_in;
   logic [AW:0] clr_ff, clr_in;

   bcow_pkg::div_req_type dreq;
   bcow_pkg::div_rsp_type drsp;

   bcow_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic req_acc;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      dreq.start = req_acc;
      dreq.dividend = req_tdata[47:0];
      dreq.divisor = dur_ff;
      dreq.modulus = ncnt;
   end

   // counter memory, one row per bucket
   logic [ROW_W-1:0] mem [MAX_BUCKETS];
   logic [ROW_W-1:0] rd_ff;
   logic we;
   logic [AW-1:0] waddr;
   logic [ROW_W-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[addr_ff];
   end

   // classification of a record against the slow threshold and the code entries
   logic slow_hit;
   logic match_any;
   logic [1:0] match_cls;
   always_comb begin
      slow_hit = mode_ff[1] && (delay_ff >= slow_ff);
      match_any = 1'b0;
      match_cls = '0;
      for (int e = bcow_pkg::NUM_ENTRIES - 1; e >= 0; e--) begin
         if (entry_ff[e][34] && entry_ff[e][31:0] == code_ff) begin
            match_any = 1'b1;
            match_cls = entry_ff[e][33:32];
         end
      end
   end

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
      sat_inc = (en && v != CNT_MAX) ? v + CW'(1) : v;
   endfunction

   logic [ROW_W-1:0] upd_row;
   always_comb begin
      upd_row = rd_ff;
      if (stat_ff == bcow_pkg::ST_OK || stat_ff == bcow_pkg::ST_ERR)
         upd_row[CW-1:0] = sat_inc(rd_ff[CW-1:0], 1'b1);
      if (stat_ff == bcow_pkg::ST_OK)
         upd_row[3*CW-1:2*CW] = sat_inc(rd_ff[3*CW-1:2*CW], slow_hit);
      if (stat_ff == bcow_pkg::ST_ERR && mode_ff[0]) begin
         if (!match_any) begin
            upd_row[2*CW-1:CW] = sat_inc(rd_ff[2*CW-1:CW], 1'b1);
         end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
               if (match_cls == 2'(c))
                  upd_row[(3+c)*CW +: CW] = sat_inc(rd_ff[(3+c)*CW +: CW], 1'b1);
            end
         end
      end
   end

   // output register
   logic rvalid_ff, rvalid_in;
   logic rlast_ff, rlast_in;
   logic [231:0] rdata_ff, rdata_in;

   logic [231:0] out_pack;
   always_comb begin
      out_pack = '0;
      out_pack[5:0] = age_ff[5:0];
      for (int f = 0; f < 3 + NUM_CLASSES; f++)
         out_pack[6 + f*CW +: CW] = rd_ff[f*CW +: CW];
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      age_in = age_ff;
      clr_in = clr_ff;
      we = 1'b0;
      waddr = addr_ff;
      wdata = '0;
      rvalid_in = rvalid_ff;
      rlast_in = rlast_ff;
      rdata_in = rdata_ff;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // one row per cycle after reset
            we = 1'b1;
            waddr = clr_ff[AW-1:0];
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff == (AW+1)'(MAX_BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) state_in = S_DIV;
         end
         S_DIV: begin
            if (drsp.done) begin
               addr_in = AW'(drsp.bucket);
               age_in = '0;
               state_in = (kind_ff == bcow_pkg::KIND_DRAIN) ? S_DREAD : S_RREAD;
            end
         end
         S_RREAD: state_in = S_RWRT;
         S_RWRT: begin
            we = 1'b1;
            wdata = upd_row;
            state_in = S_IDLE;
         end
         S_DREAD: state_in = S_DOUT;
         S_DOUT: begin
            // present one bucket once the output register is free
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdata_in = out_pack;
               rlast_in = (age_ff + BW'(1) == ncnt);
               we = 1'b1;
               wdata = '0;
               age_in = age_ff + BW'(1);
               addr_in = (addr_ff == '0) ? AW'(ncnt - BW'(1)) : addr_ff - AW'(1);
               state_in = (age_ff + BW'(1) == ncnt) ? S_IDLE : S_DREAD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rvalid_ff <= rvalid_in;
      end
      addr_ff <= addr_in;
      age_ff <= age_in;
      rlast_ff <= rlast_in;
      rdata_ff <= rdata_in;
      if (req_acc) begin
         kind_ff <= req_tuser;
         stat_ff <= req_tdata[49:48];
         delay_ff <= req_tdata[81:50];
         code_ff <= req_tdata[113:82];
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = rdata_ff;
   assign rsp_tlast = rlast_ff;

   // no new transaction while a drain is still walking
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOUT || state_ff == S_DREAD) |-> !req_tready)
      else $error("input ready during drain");
   // a drain never walks past the bucket count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DOUT |-> age_ff < ncnt)
      else $error("drain age beyond bucket count");
   // a new result is only loaded when the previous one has gone
   assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result overwritten while stalled");
endmodule

### dv/tb_bucketed_call_outcome_window.sv
// testbench for the bucketed call outcome window: directed and random records and drains vs a predictor
module tb_bucketed_call_outcome_window;

   localparam int NB = 64;
   localparam int NCNT = 7;

   // one drain report: packed like rsp_tdata, plus the last flag
   typedef struct packed {
      logic [231:0] data;
      logic         last;
   } bucket_report_type;

   // bucket counter predictor and store of expected drain reports
   class window_scoreboard;
      bit [1:0]  mode;
      bit [31:0] slow_thr;
      bit [31:0] dur;
      bit [6:0]  bcnt;
      bit [34:0] entry [bcow_pkg::NUM_ENTRIES];
      bit [31:0] total_cnt [NB];
      bit [31:0] error_cnt [NB];
      bit [31:0] slow_cnt [NB];
      bit [31:0] class_cnt [NB][4];
      bucket_report_type pending_reports[$];
      int mismatches;
      int reports_seen;
      int drains;
      int records;

      function new();
         mode = 0;
         slow_thr = 0;
         dur = 1000;
         bcnt = 23;
         mismatches = 0;
         reports_seen = 0;
         drains = 0;
         records = 0;
         foreach (entry[i]) entry[i] = '0;
         for (int b = 0; b < NB; b++) begin
            total_cnt[b] = 0;
            error_cnt[b] = 0;
            slow_cnt[b] = 0;
            for (int c = 0; c < 4; c++) class_cnt[b][c] = 0;
         end
      endfunction

      function void set_register(logic [bcow_pkg::CSR_IDX_W-1:0] idx,
                                 logic [bcow_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            bcow_pkg::REG_MODE: mode = val[1:0];
            bcow_pkg::REG_SLOW: slow_thr = val[31:0];
            bcow_pkg::REG_DUR: dur = val[31:0];
            bcow_pkg::REG_BCNT: bcnt = val[6:0];
            default: begin
               if (idx >= bcow_pkg::REG_ENTRY0)
                  entry[idx - bcow_pkg::REG_ENTRY0] = val[34:0];
            end
         endcase
      endfunction

      function int unsigned ring_size();
         int unsigned n;
         n = bcnt;
         if (n == 0) n = 1;
         if (n > NB) n = NB;
         return n;
      endfunction

      function void bump(ref bit [31:0] c);
         if (c != 32'hFFFF_FFFF) c = c + 1;
      endfunction

      // apply one accepted request; a drain queues one report per bucket
      function void note_request(logic kind, logic [47:0] t, logic [1:0] st,
                                 logic [31:0] dly, logic [31:0] code);
         longint unsigned d;
         int unsigned n, b, hit;
         bucket_report_type r;
         n = ring_size();
         d = (dur == 0) ? 1 : dur;
         b = int'((64'(t) / d) % n);
         if (kind == bcow_pkg::KIND_RECORD) begin
            records++;
            if (st == bcow_pkg::ST_OK) begin
               bump(total_cnt[b]);
               if (mode[1] && dly >= slow_thr) bump(slow_cnt[b]);
            end else if (st == bcow_pkg::ST_ERR) begin
               bump(total_cnt[b]);
               if (mode[0]) begin
                  hit = bcow_pkg::NUM_ENTRIES;
                  for (int e = bcow_pkg::NUM_ENTRIES - 1; e >= 0; e--)
                     if (entry[e][34] && entry[e][31:0] == code) hit = e;
                  if (hit == bcow_pkg::NUM_ENTRIES) bump(error_cnt[b]);
                  else bump(class_cnt[b][entry[hit][33:32]]);
               end
            end
         end else begin
            drains++;
            for (int unsigned k = 0; k < n; k++) begin
               r.data = '0;
               r.data[5:0] = k[5:0];
               r.data[37:6] = total_cnt[b];
               r.data[69:38] = error_cnt[b];
               r.data[101:70] = slow_cnt[b];
               for (int c = 0; c < 4; c++) begin
                  r.data[102 + 32*c +: 32] = class_cnt[b][c];
                  class_cnt[b][c] = 0;
               end
               r.last = (k + 1 == n);
               total_cnt[b] = 0;
               error_cnt[b] = 0;
               slow_cnt[b] = 0;
               pending_reports.insert(pending_reports.size(), r);
               b = (b == 0) ? n - 1 : b - 1;
            end
         end
      endfunction

      function void fail_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d (report %0d)",
                     name, exp_v, act_v, reports_seen);
      endfunction

      // compare one drain report with the oldest expectation
      function void check_report(logic [231:0] data, logic last);
         bucket_report_type r;
         string names [NCNT];
         names = '{"total", "error", "slow", "class0", "class1", "class2", "class3"};
         reports_seen++;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected report, nothing pending");
            return;
         end
         r = pending_reports.pop_front();
         if (data[5:0] !== r.data[5:0]) fail_field("bucket_age", r.data[5:0], data[5:0]);
         for (int i = 0; i < NCNT; i++)
            if (data[6 + 32*i +: 32] !== r.data[6 + 32*i +: 32])
               fail_field(names[i], r.data[6 + 32*i +: 32], data[6 + 32*i +: 32]);
         if (last !== r.last) fail_field("last", r.last, last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [bcow_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bcow_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   window_scoreboard sb;
   bit quiet = 1'b0;
   int rsp_stall = 0;
   logic [34:0] cfg [8];

   bucketed_call_outcome_window u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted transactions, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata, rsp_tlast);
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one request transaction, with an optional idle burst ahead of it
   task automatic send_req(logic kind, logic [47:0] t, logic [1:0] st,
                           logic [31:0] dly, logic [31:0] code);
      @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, code, dly, st, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, t, st, dly, code);
      req_tvalid <= 1'b0;
   endtask

   // wait until all reports are in and the block has finished its last record
   task automatic wait_idle();
      @(posedge clock);
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // write all registers from cfg, back to back
   task automatic write_regs();
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= i[bcow_pkg::CSR_IDX_W-1:0];
         csr_wdata <= cfg[i];
         sb.set_register(i[bcow_pkg::CSR_IDX_W-1:0], cfg[i]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [34:0] rand_entry();
      logic [31:0] code;
      case ($urandom_range(0, 5))
         0: code = 32'hFFFF_FFFF;
         1: code = 32'h0;
         2: code = 32'h7FFF_FFFF;
         3: code = 32'h8000_0000;
         default: code = $urandom_range(0, 9);
      endcase
      return {($urandom_range(0, 4) != 0) ? 1'b1 : 1'b0, 2'($urandom_range(0, 3)), code};
   endfunction

   // random phase: mostly records near a few buckets, drains mixed in, one at the end
   task automatic random_phase(int count);
      logic [47:0] t;
      logic [1:0] st;
      logic [31:0] dly, code;
      longint unsigned d;
      d = (cfg[2][31:0] == 0) ? 1 : cfg[2][31:0];
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) t = {16'($urandom), 32'($urandom)};
         else t = 48'(d * $urandom_range(0, 150) + (64'($urandom) % d));
         case ($urandom_range(0, 19))
            0, 1: st = 2'($urandom_range(2, 3));
            2, 3, 4, 5, 6, 7, 8, 9: st = bcow_pkg::ST_OK;
            default: st = bcow_pkg::ST_ERR;
         endcase
         case ($urandom_range(0, 3))
            0: dly = $urandom;
            1: dly = 32'hFFFF_FFFF;
            default: dly = cfg[1][31:0] + 32'($urandom_range(0, 2)) - 32'd1;
         endcase
         if ($urandom_range(0, 9) < 6) code = cfg[4 + $urandom_range(0, 3)][31:0];
         else code = $urandom;
         if (i == count - 1 || $urandom_range(0, 9) == 0)
            send_req(bcow_pkg::KIND_DRAIN, t, 2'($urandom), $urandom, $urandom);
         else
            send_req(bcow_pkg::KIND_RECORD, t, st, dly, code);
      end
   endtask

   initial begin
      #20_000_000;
      $display("[bucketed_call_outcome_window] ERROR");
      $finish;
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults: error call counts only in total, then a full drain
      send_req(bcow_pkg::KIND_RECORD, 48'd2500, bcow_pkg::ST_ERR, 32'd0, 32'hFFFF_FFFB);
      send_req(bcow_pkg::KIND_RECORD, 48'd2999, bcow_pkg::ST_OK, 32'hFFFF_FFFF, 32'd0);
      send_req(bcow_pkg::KIND_DRAIN, 48'd2000, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();

      // directed: overlapping codes, invalid entry, slow edges, ignored states
      cfg = '{35'd3, 35'd100, 35'd10, 35'd4,
              {1'b1, 2'd2, 32'hFFFF_FFFB}, {1'b1, 2'd0, 32'hFFFF_FFFB},
              {1'b0, 2'd1, 32'd7}, {1'b1, 2'd3, 32'h7FFF_FFFF}};
      write_regs();
      send_req(bcow_pkg::KIND_RECORD, 48'd0, bcow_pkg::ST_OK, 32'd99, 32'd0);
      send_req(bcow_pkg::KIND_RECORD, 48'd5, bcow_pkg::ST_OK, 32'd100, 32'd0);
      send_req(bcow_pkg::KIND_RECORD, 48'd15, bcow_pkg::ST_OK, 32'hFFFF_FFFF, 32'd0);
      send_req(bcow_pkg::KIND_RECORD, 48'd25, bcow_pkg::ST_ERR, 32'd0, 32'hFFFF_FFFB);
      send_req(bcow_pkg::KIND_RECORD, 48'd35, bcow_pkg::ST_ERR, 32'd0, 32'd7);
      send_req(bcow_pkg::KIND_RECORD, 48'd35, bcow_pkg::ST_ERR, 32'd0, 32'h7FFF_FFFF);
      send_req(bcow_pkg::KIND_RECORD, 48'd45, bcow_pkg::ST_ERR, 32'd0, 32'h8000_0000);
      send_req(bcow_pkg::KIND_RECORD, 48'd45, 2'd2, 32'd500, 32'hFFFF_FFFB);
      send_req(bcow_pkg::KIND_RECORD, 48'd45, 2'd3, 32'd500, 32'hFFFF_FFFB);
      send_req(bcow_pkg::KIND_RECORD, 48'hFFFF_FFFF_FFFF, bcow_pkg::ST_ERR, 32'd0,
               32'h7FFF_FFFF);
      send_req(bcow_pkg::KIND_DRAIN, 48'd17, 2'd3, 32'hFFFF_FFFF, 32'h8000_0000);
      send_req(bcow_pkg::KIND_DRAIN, 48'hFFFF_FFFF_FFFF, bcow_pkg::ST_OK, 32'd0, 32'd0);
      wait_idle();

      // random phases over several settings, extremes included; last one without idling
      for (int p = 0; p < 8; p++) begin
         cfg[0] = 35'($urandom_range(0, 3));
         cfg[1] = (p == 0) ? 35'd0 : (p == 1) ? 35'hFFFF_FFFF : 35'($urandom);
         case (p)
            0: cfg[2] = 35'd0;
            1: cfg[2] = 35'hFFFF_FFFF;
            2: cfg[2] = 35'd1;
            default: cfg[2] = 35'($urandom_range(1, 2000));
         endcase
         case (p)
            0: cfg[3] = 35'd0;
            1: cfg[3] = 35'd127;
            2: cfg[3] = 35'd64;
            3: cfg[3] = 35'd1;
            4: cfg[3] = 35'd65;
            default: cfg[3] = 35'($urandom_range(2, 40));
         endcase
         for (int e = 0; e < 4; e++) cfg[4 + e] = rand_entry();
         quiet = (p == 7);
         write_regs();
         random_phase(55);
         wait_idle();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d records and %0d drains, %0d bucket reports checked",
               sb.records, sb.drains, sb.reports_seen);
      $display("settings: 10 register sets, bucket counts 0..127, durations 0..max");
      if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
         $display("[bucketed_call_outcome_window] OK");
      end else begin
         $display("%0d mismatches, %0d reports missing", sb.mismatches,
                  sb.pending_reports.size());
         $display("[bucketed_call_outcome_window] ERROR");
      end
      $finish;
   end
endmodule

### files.f
design/bcow_pkg.sv
design/bcow_div.sv
design/bucketed_call_outcome_window.sv
dv/tb_bucketed_call_outcome_window.sv
